// File: hw/rtl/lru_pkg.sv
// Package with the shared constants and the command and status types of the key-value cache.
`default_nettype none
package lru_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int SLOT_W      = $clog2(MAX_ENTRIES);
  localparam int RANK_W      = $clog2(MAX_ENTRIES);
  localparam int CAP_W       = 5;
  localparam int KEY_W       = 32;
  localparam int VAL_W       = 32;
  localparam int PADDR_W     = 3;
  localparam int PDATA_W     = 32;

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_INSERT = 1'b1;

  localparam logic [PADDR_W-1:0] ADDR_CAPACITY = 3'd0;

  typedef struct packed {
    logic load;
    logic lookup;
    logic update;
  } cmd_t;

  typedef struct packed {
    logic busy;
  } status_t;

endpackage
`default_nettype wire

// File: hw/rtl/lru_ctrl.sv
// Controller state machine: sequences load, lookup and update and owns the output valid.
`default_nettype none
module lru_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_tvalid,
  output logic               s_tready,
  output logic               m_tvalid,
  input  wire logic          m_tready,
  output lru_pkg::cmd_t      cmd,
  output lru_pkg::status_t   status
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_LOOKUP = 2'd1;
  localparam logic [1:0] ST_UPDATE = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_valid;
  logic       out_valid_next;
  logic       out_free;

  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = out_valid;
  assign out_free = !out_valid || m_tready;
  assign status.busy = (state != ST_IDLE);

  always_comb begin
    state_next     = state;
    out_valid_next = out_valid && !m_tready;
    cmd            = '0;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        cmd.lookup = 1'b1;
        state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (out_free) begin
          cmd.update     = 1'b1;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/lru_datapath.sv
// Datapath: entry store, recency ranks, key compare, slot selection and result register.
`default_nettype none
module lru_datapath (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire lru_pkg::cmd_t                 cmd,
  input  wire logic                          cfg_we,
  input  wire logic [lru_pkg::CAP_W-1:0]     cfg_capacity,
  output logic      [lru_pkg::CAP_W-1:0]     capacity,
  input  wire logic                          in_opcode,
  input  wire logic [lru_pkg::KEY_W-1:0]     in_key,
  input  wire logic [lru_pkg::VAL_W-1:0]     in_value,
  output logic                               out_hit,
  output logic      [lru_pkg::VAL_W-1:0]     out_value
);

  logic [lru_pkg::KEY_W-1:0]  keys  [lru_pkg::MAX_ENTRIES];
  logic [lru_pkg::VAL_W-1:0]  vals  [lru_pkg::MAX_ENTRIES];
  logic [lru_pkg::RANK_W-1:0] rank  [lru_pkg::MAX_ENTRIES];
  logic [lru_pkg::MAX_ENTRIES-1:0] valid;
  logic [lru_pkg::CAP_W-1:0]  used;

  logic                       op_q;
  logic [lru_pkg::KEY_W-1:0]  key_q;
  logic [lru_pkg::VAL_W-1:0]  val_q;

  logic                       found_q;
  logic                       fill_q;
  logic [lru_pkg::SLOT_W-1:0] target_q;

  logic [lru_pkg::MAX_ENTRIES-1:0] match;
  logic                       found;
  logic                       free_any;
  logic [lru_pkg::SLOT_W-1:0] hit_slot;
  logic [lru_pkg::SLOT_W-1:0] free_slot;
  logic [lru_pkg::SLOT_W-1:0] victim_slot;
  logic [lru_pkg::CAP_W-1:0]  limit;
  logic                       full;
  logic [lru_pkg::RANK_W-1:0] oldest_rank;
  logic [lru_pkg::CAP_W-1:0]  age_lim;
  logic                       write_entry;
  logic                       new_entry;

  always_comb begin
    if (capacity == '0) begin
      limit = lru_pkg::CAP_W'(1);
    end else if (capacity > lru_pkg::CAP_W'(lru_pkg::MAX_ENTRIES)) begin
      limit = lru_pkg::CAP_W'(lru_pkg::MAX_ENTRIES);
    end else begin
      limit = capacity;
    end
  end

  assign full        = (used >= limit);
  assign oldest_rank = lru_pkg::RANK_W'(used - lru_pkg::CAP_W'(1));

  always_comb begin
    hit_slot    = '0;
    free_slot   = '0;
    victim_slot = '0;
    free_any    = 1'b0;
    for (int i = 0; i < lru_pkg::MAX_ENTRIES; i++) begin
      match[i] = valid[i] && (keys[i] == key_q);
    end
    found = |match;
    for (int i = lru_pkg::MAX_ENTRIES - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit_slot = lru_pkg::SLOT_W'(i);
      end
      if (!valid[i]) begin
        free_slot = lru_pkg::SLOT_W'(i);
        free_any  = 1'b1;
      end
      if (valid[i] && rank[i] == oldest_rank) begin
        victim_slot = lru_pkg::SLOT_W'(i);
      end
    end
  end

  assign write_entry = cmd.update && (op_q == lru_pkg::OP_INSERT);
  assign new_entry   = write_entry && fill_q;
  assign age_lim     = fill_q ? lru_pkg::CAP_W'(lru_pkg::MAX_ENTRIES)
                              : {1'b0, rank[target_q]};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q  <= in_opcode;
      key_q <= in_key;
      val_q <= in_value;
    end
    if (cmd.lookup) begin
      found_q <= found;
      fill_q  <= !found && !full && free_any;
      if (found) begin
        target_q <= hit_slot;
      end else if (full) begin
        target_q <= victim_slot;
      end else begin
        target_q <= free_slot;
      end
    end
    if (cmd.update) begin
      out_hit <= found_q;
      if (op_q == lru_pkg::OP_INSERT) begin
        out_value <= '0;
      end else if (found_q) begin
        out_value <= vals[target_q];
      end else begin
        out_value <= '1;
      end
    end
    if (write_entry) begin
      vals[target_q] <= val_q;
      if (!found_q) begin
        keys[target_q] <= key_q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= lru_pkg::CAP_W'(lru_pkg::MAX_ENTRIES);
      valid    <= '0;
      used     <= '0;
      for (int i = 0; i < lru_pkg::MAX_ENTRIES; i++) begin
        rank[i] <= '0;
      end
    end else if (cfg_we) begin
      capacity <= cfg_capacity;
      valid    <= '0;
      used     <= '0;
      for (int i = 0; i < lru_pkg::MAX_ENTRIES; i++) begin
        rank[i] <= '0;
      end
    end else if (cmd.update && (found_q || write_entry)) begin
      for (int i = 0; i < lru_pkg::MAX_ENTRIES; i++) begin
        if (lru_pkg::SLOT_W'(i) == target_q) begin
          rank[i] <= '0;
        end else if (valid[i] && ({1'b0, rank[i]} < age_lim)) begin
          rank[i] <= rank[i] + lru_pkg::RANK_W'(1);
        end
      end
      if (new_entry) begin
        valid[target_q] <= 1'b1;
        used            <= used + lru_pkg::CAP_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/lru_key_value_cache.sv
// Top level of the least-recently-used key-value cache with its configuration port.
//
//   Channel   Direction  Payload
//   s_*       in         tuser: opcode; tdata: lookup_key, write_value
//   m_*       out        tuser: hit; tdata: read_value
//   APB       in/out     capacity register at byte address 0
//
// Each transaction runs through capture, parallel key compare with slot
// selection, then store and rank update with the result loaded into the output register.
// One transaction is in flight at a time; the next is accepted while a result still waits.
// A stalled output holds the update step until the result register is free.
// Reset empties the store and sets the capacity to sixteen; a capacity write empties it too.
`default_nettype none
module lru_key_value_cache (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [63:0]                   s_tdata,   // lookup_key, write_value
  input  wire logic [0:0]                    s_tuser,   // opcode
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic      [31:0]                   m_tdata,   // read_value
  output logic      [0:0]                    m_tuser,   // hit
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [lru_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [lru_pkg::PDATA_W-1:0]   pwdata,
  output logic      [lru_pkg::PDATA_W-1:0]   prdata,
  output logic                               pready
);

  lru_pkg::cmd_t              cmd;
  lru_pkg::status_t           status;
  logic                       cfg_we;
  logic                       cap_sel;
  logic [lru_pkg::CAP_W-1:0]  capacity;
  logic                       hit;

  assign pready  = 1'b1;
  assign cap_sel = (paddr[lru_pkg::PADDR_W-1] == lru_pkg::ADDR_CAPACITY[lru_pkg::PADDR_W-1]);
  assign cfg_we  = psel && penable && pwrite && pready && cap_sel && !status.busy;
  assign prdata  = cap_sel ? lru_pkg::PDATA_W'(capacity) : '0;
  assign m_tuser = hit;

  lru_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .status   (status)
  );

  lru_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .cfg_we       (cfg_we),
    .cfg_capacity (pwdata[lru_pkg::CAP_W-1:0]),
    .capacity     (capacity),
    .in_opcode    (s_tuser[0]),
    .in_key       (s_tdata[lru_pkg::KEY_W-1:0]),
    .in_value     (s_tdata[lru_pkg::KEY_W +: lru_pkg::VAL_W]),
    .out_hit      (hit),
    .out_value    (m_tdata)
  );

endmodule
`default_nettype wire
